/* design/bmg_pkg.sv */
// ----------------------------------------------------------------------------
// bmg_pkg
// types, constants and register codes shared by the butterworth mask generator
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int GAIN_BITS_DEF = 16;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int ORDER_W    = 5;
  localparam int CUT_W      = 16;
  localparam int OUT_GAIN_W = 16;
  localparam int FC2_W      = 2 * CUT_W;
  localparam int ORDER_MAX  = (1 << ORDER_W) - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]   RESET_ROW_COUNT = CNT_W'(256);
  localparam logic [CNT_W-1:0]   RESET_COL_COUNT = CNT_W'(256);
  localparam logic               RESET_KIND      = 1'b0;
  localparam logic [ORDER_W-1:0] RESET_ORDER     = ORDER_W'(2);
  localparam logic [CUT_W-1:0]   RESET_CUTOFF    = CUT_W'(7680);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 3'd0,
    CFG_COL_COUNT = 3'd1,
    CFG_KIND      = 3'd2,
    CFG_ORDER     = 3'd3,
    CFG_CUTOFF    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   row_count;
    logic [CNT_W-1:0]   col_count;
    logic               filter_kind;
    logic [ORDER_W-1:0] filter_order;
    logic [CUT_W-1:0]   cutoff_q8;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } item_t;

  typedef struct packed {
    logic [OUT_GAIN_W-1:0] gain;
    logic [IDX_W-1:0]      dest_row;
    logic [IDX_W-1:0]      dest_col;
    logic                  index_error;
  } result_t;

  // per-bin flags and coordinates carried alongside the arithmetic
  typedef struct packed {
    logic             err;
    logic             zero;
    logic [IDX_W-1:0] dest_row;
    logic [IDX_W-1:0] dest_col;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

endpackage

/* design/butterworth_mask_generator.sv */
// ----------------------------------------------------------------------------
// butterworth_mask_generator
// butterworth gain of one frequency bin per beat, fully pipelined
// ----------------------------------------------------------------------------
// throughput: one beat per clock, busy never rises; set by the fully pipelined
//   ratio divider, the 31-factor multiply chain and the gain divider
// reset clears the valid chain and loads the register defaults; no clearing pass
// results leave on a one-cycle done_o strobe, the receiver cannot stall
module butterworth_mask_generator #(
  parameter int MAX_DIM   = bmg_pkg::MAX_DIM_DEF,
  parameter int GAIN_BITS = bmg_pkg::GAIN_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bmg_pkg::item_t                 item_i,
  output logic                           done_o,
  output bmg_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bmg_pkg::*;

  // distance widths follow the clamped count range
  localparam int CW  = $clog2(MAX_DIM + 1);
  localparam int AW  = (CW > CNT_W) ? CW : CNT_W;
  localparam int D2W = 2*AW + 1;
  // ratio in q16.16, clipped to 2^(GAIN_BITS+18)
  localparam int RW    = GAIN_BITS + 19;
  localparam int NUMW1 = RW + FC2_W;
  localparam logic [RW-1:0] CAP_V  = RW'(1) << (RW - 1);
  localparam logic [RW-1:0] GMAX_S = RW'({{GAIN_BITS{1'b1}}, 16'h0000});
  localparam int LAT = 3 + (RW + 1) + 2*ORDER_MAX + (GAIN_BITS + 1) + 1;

  // configuration registers
  cfg_t              cfg_q;
  logic [FC2_W-1:0]  fc2_q;
  logic [CUT_W-1:0]  fc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count    <= RESET_ROW_COUNT;
      cfg_q.col_count    <= RESET_COL_COUNT;
      cfg_q.filter_kind  <= RESET_KIND;
      cfg_q.filter_order <= RESET_ORDER;
      cfg_q.cutoff_q8    <= RESET_CUTOFF;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ROW_COUNT: cfg_q.row_count    <= cfg_wdata_i[CNT_W-1:0];
        CFG_COL_COUNT: cfg_q.col_count    <= cfg_wdata_i[CNT_W-1:0];
        CFG_KIND:      cfg_q.filter_kind  <= cfg_wdata_i[0];
        CFG_ORDER:     cfg_q.filter_order <= cfg_wdata_i[ORDER_W-1:0];
        CFG_CUTOFF:    cfg_q.cutoff_q8    <= cfg_wdata_i[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // squared cutoff, refreshed every cycle; a zero cutoff counts as one
  assign fc = (cfg_q.cutoff_q8 == '0) ? CUT_W'(1) : cfg_q.cutoff_q8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc2_q <= FC2_W'(RESET_CUTOFF) * FC2_W'(RESET_CUTOFF);
    end else begin
      fc2_q <= fc * fc;
    end
  end

  // every start beat is taken
  logic in_valid;
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // distance stages
  logic           d_valid;
  logic [D2W-1:0] d2;
  side_t          d_side;

  bmg_dist #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .valid_o (d_valid),
    .d2_o    (d2),
    .side_o  (d_side)
  );

  // ratio: d2/fc2 for low-pass, fc2/d2 for high-pass
  logic [NUMW1-1:0] num1;
  logic [FC2_W-1:0] den1;
  logic             r_valid, r_ovf;
  logic [RW-1:0]    r_quot, r_clip;
  logic [SIDE_W-1:0] r_side;

  always_comb begin
    if (cfg_q.filter_kind) begin
      num1 = NUMW1'(fc2_q);
      // centre bin is forced to zero gain later, keep the divisor legal
      den1 = (d2 == '0) ? FC2_W'(1) : FC2_W'(d2);
    end else begin
      num1 = NUMW1'({d2, {FC2_W{1'b0}}});
      den1 = fc2_q;
    end
  end

  bmg_div #(
    .NUMW (NUMW1),
    .DENW (FC2_W),
    .QW   (RW),
    .SW   (SIDE_W)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .num_i   (num1),
    .den_i   (den1),
    .side_i  (d_side),
    .valid_o (r_valid),
    .quot_o  (r_quot),
    .ovf_o   (r_ovf),
    .side_o  (r_side)
  );

  assign r_clip = (r_ovf || (r_quot > CAP_V)) ? CAP_V : r_quot;

  // ratio raised to the order
  logic              p_valid, p_sat;
  logic [RW-1:0]     p_val;
  logic [SIDE_W-1:0] p_side;

  bmg_pow #(
    .RW    (RW),
    .STEPS (ORDER_MAX),
    .SW    (SIDE_W)
  ) u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .r_i     (r_clip),
    .side_i  (r_side),
    .order_i (cfg_q.filter_order),
    .valid_o (p_valid),
    .p_o     (p_val),
    .sat_o   (p_sat),
    .side_o  (p_side)
  );

  // gain = round(gmax * 1.0 / (1.0 + p))
  logic [RW-1:0]        den2, num2;
  logic                 g_valid, g_ovf, g_sat;
  logic [GAIN_BITS-1:0] g_quot;
  logic [SIDE_W:0]      g_side2;
  side_t                g_side;

  assign den2 = RW'(65536) + p_val;
  assign num2 = GMAX_S + (den2 >> 1);

  bmg_div #(
    .NUMW (RW),
    .DENW (RW),
    .QW   (GAIN_BITS),
    .SW   (SIDE_W + 1)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .num_i   (num2),
    .den_i   (den2),
    .side_i  ({p_sat, p_side}),
    .valid_o (g_valid),
    .quot_o  (g_quot),
    .ovf_o   (g_ovf),
    .side_o  (g_side2)
  );

  assign g_sat  = g_side2[SIDE_W];
  assign g_side = side_t'(g_side2[SIDE_W-1:0]);

  // output register
  logic    done_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= g_valid;
    end
  end

  // quotient never overflows here since the divisor is at least 1.0
  always_ff @(posedge clk_i) begin
    res_q.gain        <= (g_side.err || g_side.zero || g_sat || g_ovf) ?
                         '0 : OUT_GAIN_W'(g_quot);
    res_q.dest_row    <= g_side.dest_row;
    res_q.dest_col    <= g_side.dest_col;
    res_q.index_error <= g_side.err;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every beat comes out a fixed latency later, and nothing else does
  a_lat_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("accepted beat did not produce a result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_transpose : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.dest_row == $past(item_i.second_index, LAT)) &&
               (result_o.dest_col == $past(item_i.first_index, LAT)))
    else $error("result coordinates out of step with the pipeline");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.index_error |-> result_o.gain == '0)
    else $error("out-of-range bin with nonzero gain");

endmodule

/* design/bmg_dist.sv */
// ----------------------------------------------------------------------------
// bmg_dist
// range check and squared distance from the mask centre, three stages
// ----------------------------------------------------------------------------
module bmg_dist #(
  parameter int MAX_DIM = bmg_pkg::MAX_DIM_DEF,
  parameter int AW      = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bmg_pkg::item_t     item_i,
  input  bmg_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output logic [2*AW:0]      d2_o,
  output bmg_pkg::side_t     side_o
);
  import bmg_pkg::*;

  localparam logic [AW-1:0] MAX_V = AW'(MAX_DIM);

  logic [AW-1:0] rc, cc, fi, si, hr, hc, adx, ady;
  logic          err;

  logic [2:0]        v_q;
  logic [AW-1:0]     adx_q, ady_q;
  logic [2*AW-1:0]   sqx_q, sqy_q;
  logic [2*AW:0]     d2_q;
  side_t             sa_q, sb_q, sc_q;

  always_comb begin
    rc  = (AW'(cfg_i.row_count) > MAX_V) ? MAX_V : AW'(cfg_i.row_count);
    cc  = (AW'(cfg_i.col_count) > MAX_V) ? MAX_V : AW'(cfg_i.col_count);
    fi  = AW'(item_i.first_index);
    si  = AW'(item_i.second_index);
    hr  = rc >> 1;
    hc  = cc >> 1;
    err = (fi >= rc) || (si >= cc);
    adx = (fi >= hr) ? (fi - hr) : (hr - fi);
    ady = (si >= hc) ? (si - hc) : (hc - si);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q          <= adx;
    ady_q          <= ady;
    sa_q.err       <= err;
    sa_q.zero      <= 1'b0;
    sa_q.dest_row  <= item_i.second_index;
    sa_q.dest_col  <= item_i.first_index;
    sqx_q          <= adx_q * adx_q;
    sqy_q          <= ady_q * ady_q;
    sb_q           <= sa_q;
    d2_q           <= (2*AW+1)'(sqx_q) + (2*AW+1)'(sqy_q);
    sc_q.err       <= sb_q.err;
    sc_q.dest_row  <= sb_q.dest_row;
    sc_q.dest_col  <= sb_q.dest_col;
    // high-pass centre bin
    sc_q.zero      <= cfg_i.filter_kind && (sqx_q == '0) && (sqy_q == '0);
  end

  assign valid_o = v_q[2];
  assign d2_o    = d2_q;
  assign side_o  = sc_q;

endmodule

/* design/bmg_div.sv */
// ----------------------------------------------------------------------------
// bmg_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module bmg_div #(
  parameter int NUMW = 67,
  parameter int DENW = 32,
  parameter int QW   = 35,
  parameter int SW   = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quot_o,
  output logic            ovf_o,
  output logic [SW-1:0]   side_o
);

  logic [QW:0]     v_q;
  logic [DENW-1:0] rem_q  [QW+1];
  logic [QW-1:0]   low_q  [QW+1];
  logic [QW-1:0]   quot_q [QW+1];
  logic [DENW-1:0] den_q  [QW+1];
  logic            ovf_q  [QW+1];
  logic [SW-1:0]   side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  // quotient would not fit in QW bits
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DENW'(num_i[NUMW-1:QW]);
    low_q[0]  <= num_i[QW-1:0];
    quot_q[0] <= '0;
    den_q[0]  <= den_i;
    ovf_q[0]  <= DENW'(num_i[NUMW-1:QW]) >= den_i;
    side_q[0] <= side_i;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DENW:0] trial;
    logic [DENW:0] diff;
    logic          ge;

    always_comb begin
      trial = {rem_q[i-1], low_q[i-1][QW-1]};
      ge    = trial >= {1'b0, den_q[i-1]};
      diff  = trial - {1'b0, den_q[i-1]};
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      low_q[i]  <= low_q[i-1] << 1;
      quot_q[i] <= (quot_q[i-1] << 1) | QW'(ge);
      den_q[i]  <= den_q[i-1];
      ovf_q[i]  <= ovf_q[i-1];
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = quot_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

/* design/bmg_pow.sv */
// ----------------------------------------------------------------------------
// bmg_pow
// repeated rounded q16.16 multiply with saturation, two stages per factor
// ----------------------------------------------------------------------------
module bmg_pow #(
  parameter int RW    = 35,
  parameter int STEPS = bmg_pkg::ORDER_MAX,
  parameter int SW    = bmg_pkg::SIDE_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [RW-1:0]               r_i,
  input  logic [SW-1:0]               side_i,
  input  logic [bmg_pkg::ORDER_W-1:0] order_i,
  output logic                        valid_o,
  output logic [RW-1:0]               p_o,
  output logic                        sat_o,
  output logic [SW-1:0]               side_o
);
  import bmg_pkg::*;

  localparam int HALF = (RW + 1) / 2;
  localparam int HI   = RW - HALF;
  localparam int SUMW = (2*RW + 1 > 65) ? 2*RW + 1 : 65;
  localparam logic [SUMW-1:0] CAP_S = SUMW'(1) << (RW - 1);

  // chain taps: index k feeds factor k
  logic          vc   [STEPS+1];
  logic [RW-1:0] pc   [STEPS+1];
  logic [RW-1:0] rc   [STEPS+1];
  logic          sc   [STEPS+1];
  logic [SW-1:0] sdc  [STEPS+1];

  logic [STEPS-1:0] va_q, vb_q;

  assign vc[0]  = valid_i;
  assign pc[0]  = RW'(65536);
  assign rc[0]  = r_i;
  assign sc[0]  = 1'b0;
  assign sdc[0] = side_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_fac
    logic [RW+HALF-1:0] pl_q;
    logic [RW+HI-1:0]   ph_q;
    logic [RW-1:0]      pa_q, ra_q, pb_q, rb_q;
    logic               sa_q, sb_q;
    logic [SW-1:0]      da_q, db_q;
    logic [SUMW-1:0]    sum, pn;
    logic               act, over;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[k] <= 1'b0;
        vb_q[k] <= 1'b0;
      end else begin
        va_q[k] <= vc[k];
        vb_q[k] <= va_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      pl_q <= pc[k] * rc[k][HALF-1:0];
      ph_q <= pc[k] * rc[k][RW-1:HALF];
      pa_q <= pc[k];
      ra_q <= rc[k];
      sa_q <= sc[k];
      da_q <= sdc[k];
    end

    always_comb begin
      sum  = SUMW'(pl_q) + (SUMW'(ph_q) << HALF) + SUMW'(32768);
      pn   = sum >> 16;
      act  = ORDER_W'(k) < order_i;
      over = (|sum[SUMW-1:64]) || (pn > CAP_S);
    end

    always_ff @(posedge clk_i) begin
      rb_q <= ra_q;
      db_q <= da_q;
      if (act && !sa_q && over) begin
        sb_q <= 1'b1;
        pb_q <= pa_q;
      end else if (act && !sa_q) begin
        sb_q <= 1'b0;
        pb_q <= pn[RW-1:0];
      end else begin
        sb_q <= sa_q;
        pb_q <= pa_q;
      end
    end

    assign vc[k+1]  = vb_q[k];
    assign pc[k+1]  = pb_q;
    assign rc[k+1]  = rb_q;
    assign sc[k+1]  = sb_q;
    assign sdc[k+1] = db_q;
  end

  assign valid_o = vc[STEPS];
  assign p_o     = pc[STEPS];
  assign sat_o   = sc[STEPS];
  assign side_o  = sdc[STEPS];

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the butterworth mask generator: a queue-fed driver
// sends bin coordinates in random bursts, a monitor compares every done_o
// beat against a bit-exact gain predictor, across many register settings
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmg_pkg::*;

  localparam int DRAIN_CYCLES = 130;   // pipeline latency plus margin
  localparam int IDLE_LIMIT   = 3000;  // cycles with no beat before giving up

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  item_t             item_i = '0;
  logic              done_o;
  result_t           result_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // bench copy of the register file
  logic [CNT_W-1:0]   row_count_m = RESET_ROW_COUNT;
  logic [CNT_W-1:0]   col_count_m = RESET_COL_COUNT;
  logic               kind_m      = RESET_KIND;
  logic [ORDER_W-1:0] order_m     = RESET_ORDER;
  logic [CUT_W-1:0]   cutoff_m    = RESET_CUTOFF;

  item_t   bins_to_send[$];
  result_t gains_due[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      gap_left = 0;
  int      burst_left = 0;
  logic    beat_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  butterworth_mask_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // counts above the mask limit behave as the limit
  function automatic longint unsigned clamp_dim(logic [CNT_W-1:0] c);
    return (c > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : longint'(c);
  endfunction

  // butterworth gain of one bin from its squared distance, q0.16
  function automatic longint unsigned butter_gain(longint unsigned d2);
    longint unsigned cap, fc, fc2, r, p, den, gmax;
    cap  = 64'd1 << (GAIN_BITS_DEF + 18);
    gmax = (64'd1 << GAIN_BITS_DEF) - 1;
    fc   = (cutoff_m == 0) ? 64'd1 : longint'(cutoff_m);
    fc2  = fc * fc;
    p    = 64'd65536;
    if (kind_m) begin
      // high-pass centre bin is fully stopped
      if (d2 == 0) return 0;
      r = fc2 / d2;
    end else begin
      r = (d2 << 32) / fc2;
    end
    if (r > cap) r = cap;
    for (int k = 0; k < order_m; k++) begin
      if (r == 0) begin
        p = 0;
      end else begin
        // power saturation drives the gain to zero
        if (p > (64'hFFFF_FFFF_FFFF_FFFF - 64'd32768) / r) return 0;
        p = (p * r + 64'd32768) >> 16;
        if (p > cap) return 0;
      end
    end
    den = 64'd65536 + p;
    return (gmax * 64'd65536 + den / 2) / den;
  endfunction

  function automatic result_t predict_bin(item_t it);
    result_t         res;
    longint unsigned rc, cc, d2;
    longint          dx, dy;
    rc = clamp_dim(row_count_m);
    cc = clamp_dim(col_count_m);
    res.dest_row    = it.second_index;
    res.dest_col    = it.first_index;
    res.index_error = (it.first_index >= rc) || (it.second_index >= cc);
    res.gain        = '0;
    if (!res.index_error) begin
      dx = longint'(it.first_index) - longint'(rc / 2);
      dy = longint'(it.second_index) - longint'(cc / 2);
      d2 = dx * dx + dy * dy;
      res.gain = OUT_GAIN_W'(butter_gain(d2));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: bursts of beats separated by random gaps, all at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!start || beat_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (bins_to_send.size() > 0) begin
        item_i <= bins_to_send.pop_front();
        start  <= 1'b1;
        if (burst_left <= 1) begin
          // occasional long unbroken stretches, otherwise short bursts
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
          gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: record accepted beats, check result strobes
  always @(posedge clk_i) begin
    result_t want;
    beat_taken <= start && !busy && rst_ni;
    if (rst_ni) begin
      if (start && !busy) gains_due.push_back(predict_bin(item_i));
      if (done_o) begin
        if (gains_due.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          mismatches++;
        end else begin
          want = gains_due.pop_front();
          if (result_o.gain != want.gain)
            report_mismatch("gain", result_o.gain, want.gain);
          if (result_o.dest_row != want.dest_row)
            report_mismatch("dest_row", result_o.dest_row, want.dest_row);
          if (result_o.dest_col != want.dest_col)
            report_mismatch("dest_col", result_o.dest_col, want.dest_col);
          if (result_o.index_error != want.index_error)
            report_mismatch("index_error", result_o.index_error, want.index_error);
        end
      end
    end
  end

  // watchdog on cycles without any beat in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // register write while the pipeline is empty, mirrored into the bench copy
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ROW_COUNT: row_count_m = val[CNT_W-1:0];
      CFG_COL_COUNT: col_count_m = val[CNT_W-1:0];
      CFG_KIND:      kind_m      = val[0];
      CFG_ORDER:     order_m     = val[ORDER_W-1:0];
      CFG_CUTOFF:    cutoff_m    = val[CUT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int rows, int cols, int kind, int order, int cut);
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(CFG_COL_COUNT, CFG_DATA_W'(cols));
    write_reg(CFG_KIND, CFG_DATA_W'(kind));
    write_reg(CFG_ORDER, CFG_DATA_W'(order));
    write_reg(CFG_CUTOFF, CFG_DATA_W'(cut));
  endtask

  function automatic item_t make_bin(longint f, longint s);
    item_t it;
    it.first_index  = IDX_W'(f);
    it.second_index = IDX_W'(s);
    return it;
  endfunction

  // centre bin, its neighbour and the last row at the highest second index
  task automatic queue_directed();
    longint rc, cc;
    rc = clamp_dim(row_count_m);
    cc = clamp_dim(col_count_m);
    bins_to_send.push_back(make_bin(rc / 2, cc / 2));
    bins_to_send.push_back(make_bin(rc / 2 + 1, cc / 2));
    bins_to_send.push_back(make_bin(rc == 0 ? 0 : rc - 1, 1023));
  endtask

  // mostly in-range bins, many near the centre, some anywhere
  task automatic queue_random(int n);
    longint rc, cc, spread;
    int     pick;
    rc = clamp_dim(row_count_m);
    cc = clamp_dim(col_count_m);
    spread = (cutoff_m >> 8) * 2 + 2;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2 || rc == 0 || cc == 0)
        bins_to_send.push_back(make_bin($urandom_range(0, 1023), $urandom_range(0, 1023)));
      else if (pick < 6)
        bins_to_send.push_back(make_bin($urandom_range(0, rc - 1), $urandom_range(0, cc - 1)));
      else
        bins_to_send.push_back(make_bin(
          rc / 2 + longint'($urandom_range(0, 2 * spread)) - spread,
          cc / 2 + longint'($urandom_range(0, 2 * spread)) - spread));
    end
  endtask

  // waits until every queued bin is sent and every expected beat is back, then the pipe drains
  task automatic drain();
    while (bins_to_send.size() > 0 || start || gains_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int ords[4];
    ords = '{0, 1, 16, 31};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults first
    queue_directed();
    drain();

    // directed settings: count extremes, both kinds, order and cutoff extremes
    set_config(1, 1, 0, 0, 0);         queue_directed(); drain();
    set_config(1024, 1024, 0, 16, 65535); queue_directed(); drain();
    set_config(2047, 2047, 1, 1, 1);   queue_directed(); drain();
    set_config(0, 0, 1, 2, 7680);      queue_directed(); drain();
    set_config(1024, 3, 1, 31, 65535); queue_directed(); drain();
    set_config(5, 1024, 0, 31, 1);     queue_directed(); drain();
    set_config(512, 300, 1, 0, 2560);  queue_directed(); drain();

    // random settings
    for (int ph = 0; ph < 20; ph++) begin
      set_config(
        $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 1024),
        $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 1024),
        $urandom_range(0, 1),
        $urandom_range(0, 4) == 0 ? ords[$urandom_range(0, 3)] : $urandom_range(0, 16),
        $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(256, 16384));
      queue_random(97);
      drain();
    end

    if (mismatches == 0 && gains_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
